/* rtl/lsc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register codes, arctangent table and stage payload types.
package lsc_pkg;

  localparam int FRAC_BITS        = 12;
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int TBL_LEN          = 24;
  localparam int ANG_FRAC         = 30;

  localparam int FIELD_W    = 16;
  localparam int LIM_W      = 15;
  localparam int CFG_ADDR_W = 3;

  // Gain times error: 17-bit signed by 16-bit signed
  localparam int MUL_W = 2 * FIELD_W + 1;
  localparam int PD_W  = MUL_W + 1 - FRAC_BITS;
  localparam int CRD_W = MUL_W + 1;
  localparam int ANG_W = 32;
  localparam int ZR_W  = ANG_W - (ANG_FRAC - FRAC_BITS);
  localparam int SUM_W = PD_W + 1;

  // Motor level divider: quotient saturates at one, so FRAC_BITS+1 bits suffice
  localparam int QW        = FRAC_BITS + 1;
  localparam int DIV_STEPS = QW;
  localparam int DEN_W     = FIELD_W + 4;
  localparam int NUM_W     = FIELD_W + FRAC_BITS + 3;
  localparam int REM_W     = DEN_W + QW;

  localparam logic [QW-1:0] LEVEL_FULL = QW'(1) << FRAC_BITS;

  // atan(2^-i) with ANG_FRAC fraction bits
  localparam logic [ANG_W-1:0] ATAN_TBL [TBL_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048575, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_HEADING_GAIN = 3'd1,
    REG_WHEEL_BASE   = 3'd2,
    REG_STEER_LIMIT  = 3'd3,
    REG_SPEED_TARGET = 3'd4,
    REG_SPEED_FULL   = 3'd5
  } lsc_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] prop_gain;
    logic [FIELD_W-1:0] heading_gain;
    logic [FIELD_W-1:0] wheel_base;
    logic [LIM_W-1:0]   steer_limit;
    logic [FIELD_W-1:0] speed_target;
    logic [FIELD_W-1:0] speed_full;
  } lsc_cfg_t;

  localparam lsc_cfg_t CFG_RST = '{
    prop_gain:    16'd4096,
    heading_gain: 16'd410,
    wheel_base:   16'd1057,
    steer_limit:  15'd2130,
    speed_target: 16'd2048,
    speed_full:   16'd8192
  };

  // Products and divider operands after the first stage
  typedef struct packed {
    logic signed [MUL_W-1:0] p_lat;
    logic signed [MUL_W-1:0] p_head;
    logic signed [MUL_W-1:0] p_ff;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
  } lsc_mul_t;

  // Word carried along the cell chain
  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    neg;
    logic                    zero;
    logic signed [PD_W-1:0]  pd;
    logic [REM_W-1:0]        rem;
    logic [QW-1:0]           quo;
    logic [DEN_W-1:0]        den;
    logic                    ovf;
  } lsc_cell_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] ang;
    logic [QW-1:0]           level;
  } lsc_fin_t;

endpackage

/* rtl/lsc_front.sv */
`timescale 1ns / 1ps
// Front stages: gain products, divider operands, then PD rounding and chain setup.
module lsc_front import lsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lsc_cfg_t                  cfg,
  input  logic                      in_v,
  output logic                      in_rdy,
  input  logic signed [FIELD_W-1:0] lat,
  input  logic signed [FIELD_W-1:0] head,
  input  logic signed [FIELD_W-1:0] curv,
  output logic                      out_v,
  input  logic                      out_rdy,
  output lsc_cell_t                 out_d
);

  localparam int CUT_W = FIELD_W + 5;

  logic      a_v_r, a_v_nxt, a_rdy;
  lsc_mul_t  a_r, a_nxt;
  logic      b_v_r, b_v_nxt, b_rdy;
  lsc_cell_t b_r, b_nxt;

  logic [FIELD_W-1:0]    acurv;
  logic [CUT_W-1:0]      curv20;
  logic                  cut;
  logic [NUM_W-1:0]      num1, num7;
  logic [DEN_W-1:0]      den1, den10;
  logic signed [MUL_W:0] pd_sum;

  assign a_rdy  = !a_v_r || b_rdy;
  assign b_rdy  = !b_v_r || out_rdy;
  assign in_rdy = a_rdy;
  assign out_v  = b_v_r;
  assign out_d  = b_r;

  // Stage A: products and divider operands, 70% cut on sharp curves
  always_comb begin
    acurv  = curv[FIELD_W-1] ? FIELD_W'(-curv) : FIELD_W'(curv);
    curv20 = (CUT_W'(acurv) << 4) + (CUT_W'(acurv) << 2);
    cut    = curv20 > (CUT_W'(1) << FRAC_BITS);
    num1   = NUM_W'(cfg.speed_target) << FRAC_BITS;
    num7   = (num1 << 3) - num1;
    den1   = DEN_W'(cfg.speed_full);
    den10  = (den1 << 3) + (den1 << 1);

    a_nxt.p_lat  = MUL_W'($signed({1'b0, cfg.prop_gain})) * MUL_W'(lat);
    a_nxt.p_head = MUL_W'($signed({1'b0, cfg.heading_gain})) * MUL_W'(head);
    a_nxt.p_ff   = MUL_W'($signed({1'b0, cfg.wheel_base})) * MUL_W'(curv);
    if (cut) begin
      a_nxt.num = num7 + NUM_W'(den10 >> 1);
      a_nxt.den = den10;
    end else begin
      a_nxt.num = num1 + NUM_W'(den1 >> 1);
      a_nxt.den = den1;
    end
    a_v_nxt = a_rdy ? in_v : a_v_r;
  end

  // Stage B: round PD sum once, seed the rotation and the divider
  always_comb begin
    pd_sum = (MUL_W+1)'(a_r.p_lat) + (MUL_W+1)'(a_r.p_head)
           + ((MUL_W+1)'(1) << (FRAC_BITS - 1));
    b_nxt.pd   = PD_W'(pd_sum >>> FRAC_BITS);
    b_nxt.x    = CRD_W'(1) << (2 * FRAC_BITS);
    b_nxt.y    = a_r.p_ff[MUL_W-1] ? -CRD_W'(a_r.p_ff) : CRD_W'(a_r.p_ff);
    b_nxt.z    = '0;
    b_nxt.neg  = a_r.p_ff[MUL_W-1];
    b_nxt.zero = (a_r.p_ff == '0);
    b_nxt.rem  = REM_W'(a_r.num);
    b_nxt.quo  = '0;
    b_nxt.den  = a_r.den;
    // quotient beyond the register range: saturate, also covers a zero divisor
    b_nxt.ovf  = REM_W'(a_r.num) >= (REM_W'(a_r.den) << DIV_STEPS);
    b_v_nxt    = b_rdy ? a_v_r : b_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_v) begin
      a_r <= a_nxt;
    end
    if (b_rdy && a_v_r) begin
      b_r <= b_nxt;
    end
  end

endmodule

/* rtl/lsc_cell.sv */
`timescale 1ns / 1ps
// Chain cell: one vectoring rotation step and one restoring division step, each enabled by its parameter.
module lsc_cell import lsc_pkg::*; #(
  parameter int STEP   = 0,
  parameter bit DO_ROT = 1'b1,
  parameter bit DO_DIV = 1'b1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_v,
  output logic      in_rdy,
  input  lsc_cell_t in_d,
  output logic      out_v,
  input  logic      out_rdy,
  output lsc_cell_t out_d
);

  localparam int TIDX = (STEP < TBL_LEN) ? STEP : 0;
  localparam int DBIT = (DO_DIV && STEP < DIV_STEPS) ? DIV_STEPS - 1 - STEP : 0;
  localparam logic signed [ANG_W-1:0] ATAN_C = ATAN_TBL[TIDX];

  logic                    v_r, v_nxt;
  lsc_cell_t               d_r, d_nxt;
  logic signed [CRD_W-1:0] xs, ys;
  logic [REM_W-1:0]        trial;

  assign in_rdy = !v_r || out_rdy;
  assign out_v  = v_r;
  assign out_d  = d_r;

  always_comb begin
    d_nxt = in_d;
    xs    = $signed(in_d.x) >>> STEP;
    ys    = $signed(in_d.y) >>> STEP;
    trial = REM_W'(in_d.den) << DBIT;
    if (DO_ROT) begin
      // drive y towards zero, accumulate the angle turned
      if (!in_d.y[CRD_W-1]) begin
        d_nxt.x = in_d.x + ys;
        d_nxt.y = in_d.y - xs;
        d_nxt.z = in_d.z + ATAN_C;
      end else begin
        d_nxt.x = in_d.x - ys;
        d_nxt.y = in_d.y + xs;
        d_nxt.z = in_d.z - ATAN_C;
      end
    end
    if (DO_DIV && in_d.rem >= trial) begin
      d_nxt.rem       = in_d.rem - trial;
      d_nxt.quo[DBIT] = 1'b1;
    end
    v_nxt = in_rdy ? in_v : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      d_r <= d_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_rdy |=> v_r && $stable(d_r))
    else $error("cell word changed while held");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !d_r.ovf |-> d_r.rem < (REM_W'(d_r.den) << DBIT))
    else $error("division remainder out of range");
`endif

endmodule

/* rtl/lsc_back.sv */
`timescale 1ns / 1ps
// Back stages: round the angle, add PD term, saturate level, clamp and output register.
module lsc_back import lsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [LIM_W-1:0]          steer_limit,
  input  logic                      in_v,
  output logic                      in_rdy,
  input  lsc_cell_t                 in_d,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] out_steer_angle,
  output logic [QW-1:0]             out_drive_level,
  output logic                      out_steer_limited
);

  localparam int ZSH = ANG_FRAC - FRAC_BITS;

  logic     c_v_r, c_v_nxt, c_rdy;
  lsc_fin_t c_r, c_nxt;
  logic     o_rdy;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [FIELD_W-1:0] angle_r, angle_nxt;
  logic [QW-1:0]             level_r, level_nxt;
  logic                      limited_r, limited_nxt;

  logic signed [ANG_W-1:0] zsum;
  logic signed [ZR_W-1:0]  zr;
  logic signed [ZR_W:0]    ff;
  logic signed [SUM_W-1:0] lim;

  assign c_rdy  = !c_v_r || o_rdy;
  assign o_rdy  = !out_valid_r || !out_stall;
  assign in_rdy = c_rdy;

  assign out_valid         = out_valid_r;
  assign out_steer_angle   = angle_r;
  assign out_drive_level   = level_r;
  assign out_steer_limited = limited_r;

  always_comb begin
    zsum = in_d.z + (ANG_W'(1) << (ZSH - 1));
    zr   = ZR_W'(zsum >>> ZSH);
    if (in_d.zero) begin
      ff = '0;
    end else if (in_d.neg) begin
      ff = -(ZR_W+1)'(zr);
    end else begin
      ff = (ZR_W+1)'(zr);
    end
    c_nxt.ang = SUM_W'(in_d.pd) + SUM_W'(ff);
    if (in_d.ovf || in_d.quo > LEVEL_FULL) begin
      c_nxt.level = LEVEL_FULL;
    end else begin
      c_nxt.level = in_d.quo;
    end
    c_v_nxt = c_rdy ? in_v : c_v_r;
  end

  // Clamp to the steering limit, flag only when strictly beyond it
  always_comb begin
    lim = SUM_W'($signed({1'b0, steer_limit}));
    priority if (c_r.ang > lim) begin
      angle_nxt   = FIELD_W'(lim);
      limited_nxt = 1'b1;
    end else if (c_r.ang < -lim) begin
      angle_nxt   = FIELD_W'(-lim);
      limited_nxt = 1'b1;
    end else begin
      angle_nxt   = FIELD_W'(c_r.ang);
      limited_nxt = 1'b0;
    end
    level_nxt     = c_r.level;
    out_valid_nxt = o_rdy ? c_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      c_v_r       <= c_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && in_v) begin
      c_r <= c_nxt;
    end
    if (o_rdy && c_v_r) begin
      angle_r   <= angle_nxt;
      level_r   <= level_nxt;
      limited_r <= limited_nxt;
    end
  end

endmodule

/* rtl/lane_steering_controller_core.sv */
`timescale 1ns / 1ps
// Lane steering controller: config registers, front stages, cell chain, back stages.
// Pipeline: front stages A and B, NUM_CELLS chain cells, back stage C and the output register;
//   NUM_CELLS is the larger of the rotation step count (at most 24) and the 13 quotient bits.
// Throughput: one word per cycle while out_stall is low; every stage and cell holds its own
//   word, so bubbles close up.
// Reset: synchronous, clears all valid flags and reloads the register defaults.
module lane_steering_controller_core import lsc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [FIELD_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [FIELD_W-1:0] in_lateral_error,
  input  logic signed [FIELD_W-1:0] in_heading_error,
  input  logic signed [FIELD_W-1:0] in_path_curvature,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FIELD_W-1:0] out_steer_angle,
  output logic [QW-1:0]             out_drive_level,
  output logic                      out_steer_limited
);

  localparam int ROT_CELLS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
  localparam int NUM_CELLS = (ROT_CELLS > DIV_STEPS) ? ROT_CELLS : DIV_STEPS;

  lsc_cfg_t cfg_r, cfg_nxt;
  logic     in_rdy;

  logic      ch_v   [NUM_CELLS+1];
  logic      ch_rdy [NUM_CELLS+1];
  lsc_cell_t ch_d   [NUM_CELLS+1];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_PROP_GAIN:    cfg_nxt.prop_gain    = cfg_wdata;
        REG_HEADING_GAIN: cfg_nxt.heading_gain = cfg_wdata;
        REG_WHEEL_BASE:   cfg_nxt.wheel_base   = cfg_wdata;
        REG_STEER_LIMIT:  cfg_nxt.steer_limit  = cfg_wdata[LIM_W-1:0];
        REG_SPEED_TARGET: cfg_nxt.speed_target = cfg_wdata;
        REG_SPEED_FULL:   cfg_nxt.speed_full   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = !in_rdy;

  lsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_v    (in_valid),
    .in_rdy  (in_rdy),
    .lat     (in_lateral_error),
    .head    (in_heading_error),
    .curv    (in_path_curvature),
    .out_v   (ch_v[0]),
    .out_rdy (ch_rdy[0]),
    .out_d   (ch_d[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    lsc_cell #(
      .STEP   (k),
      .DO_ROT (k < ROT_CELLS),
      .DO_DIV (k < DIV_STEPS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (ch_v[k]),
      .in_rdy  (ch_rdy[k]),
      .in_d    (ch_d[k]),
      .out_v   (ch_v[k+1]),
      .out_rdy (ch_rdy[k+1]),
      .out_d   (ch_d[k+1])
    );
  end

  lsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .steer_limit       (cfg_r.steer_limit),
    .in_v              (ch_v[NUM_CELLS]),
    .in_rdy            (ch_rdy[NUM_CELLS]),
    .in_d              (ch_d[NUM_CELLS]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_steer_angle   (out_steer_angle),
    .out_drive_level   (out_drive_level),
    .out_steer_limited (out_steer_limited)
  );

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_level <= LEVEL_FULL)
    else $error("drive level above full scale");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output register empty");
`endif

endmodule

/* tb/sv/lane_steering_controller_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the lane steering controller core: stepwise prediction, random flow.
module lane_steering_controller_core_tb;
  import lsc_pkg::*;

  localparam int      CLK_HALF   = 10;
  localparam longint  RUN_LIMIT  = 64'd12_000_000;
  localparam int      TAIL_WAIT  = 40;
  localparam int      PHASES     = 8;
  localparam int      PER_PHASE  = 130;
  localparam int      ROT_STEPS  = (CORDIC_STEPS_DEF < TBL_LEN) ? CORDIC_STEPS_DEF : TBL_LEN;
  localparam longint  ONE        = 64'sd1 << FRAC_BITS;

  // atan(2^-i), 30 fraction bits
  localparam longint ATAN_STEP [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] angle;
    logic [QW-1:0]             level;
    logic                      limited;
  } steer_cmd_t;

  class steer_cmd_ledger;
    logic [FIELD_W-1:0] prop_gain, heading_gain, wheel_base, speed_target, speed_full;
    logic [LIM_W-1:0]   steer_limit;
    steer_cmd_t         cmd_due[$];
    int                 errors;

    function new();
      prop_gain    = CFG_RST.prop_gain;
      heading_gain = CFG_RST.heading_gain;
      wheel_base   = CFG_RST.wheel_base;
      steer_limit  = CFG_RST.steer_limit;
      speed_target = CFG_RST.speed_target;
      speed_full   = CFG_RST.speed_full;
      errors       = 0;
    endfunction

    function void set_reg(lsc_reg_t r, logic [FIELD_W-1:0] v);
      case (r)
        REG_PROP_GAIN:    prop_gain    = v;
        REG_HEADING_GAIN: heading_gain = v;
        REG_WHEEL_BASE:   wheel_base   = v;
        REG_STEER_LIMIT:  steer_limit  = v[LIM_W-1:0];
        REG_SPEED_TARGET: speed_target = v;
        REG_SPEED_FULL:   speed_full   = v;
        default: ;
      endcase
    endfunction

    // Vectoring rotation on |p|, sign restored afterwards
    function longint feedforward(longint p);
      longint x, y, z, xs, ys;
      if (p == 0) return 0;
      x = 64'sd1 << (2 * FRAC_BITS);
      y = (p < 0) ? -p : p;
      z = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
        end
      end
      z = (z + (64'sd1 << (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
      return (p < 0) ? -z : z;
    endfunction

    function steer_cmd_t steer_law(logic signed [FIELD_W-1:0] lat,
                                   logic signed [FIELD_W-1:0] head,
                                   logic signed [FIELD_W-1:0] curv);
      longint     pd, ang, lim, acurv, num, den, lvl;
      steer_cmd_t c;
      pd = (longint'(prop_gain) * longint'(lat) + longint'(heading_gain) * longint'(head)
            + (ONE >>> 1)) >>> FRAC_BITS;
      ang = pd + feedforward(longint'(wheel_base) * longint'(curv));
      lim = longint'(steer_limit);
      c.limited = 1'b0;
      if (ang > lim) begin
        ang = lim; c.limited = 1'b1;
      end else if (ang < -lim) begin
        ang = -lim; c.limited = 1'b1;
      end
      acurv = (curv < 0) ? -longint'(curv) : longint'(curv);
      if (speed_full == '0) begin
        lvl = ONE;
      end else begin
        num = longint'(speed_target) << FRAC_BITS;
        den = longint'(speed_full);
        // cut to 70% on tight bends
        if (acurv * 20 > ONE) begin
          num = num * 7; den = den * 10;
        end
        lvl = (num + den / 2) / den;
        if (lvl > ONE) lvl = ONE;
      end
      c.angle = ang[FIELD_W-1:0];
      c.level = lvl[QW-1:0];
      return c;
    endfunction

    function void note_sample(logic signed [FIELD_W-1:0] lat,
                              logic signed [FIELD_W-1:0] head,
                              logic signed [FIELD_W-1:0] curv);
      cmd_due.push_back(steer_law(lat, head, curv));
    endfunction

    function void check_cmd(logic signed [FIELD_W-1:0] angle, logic [QW-1:0] level,
                            logic limited);
      steer_cmd_t e;
      if (cmd_due.size() == 0) begin
        $display("%0t: unexpected word angle %0d level %0d limited %0b",
                 $time, angle, level, limited);
        errors++;
        return;
      end
      e = cmd_due.pop_front();
      if (angle !== e.angle) begin
        $display("%0t: steer_angle expected %0d got %0d", $time, e.angle, angle);
        errors++;
      end
      if (level !== e.level) begin
        $display("%0t: drive_level expected %0d got %0d", $time, e.level, level);
        errors++;
      end
      if (limited !== e.limited) begin
        $display("%0t: steer_limited expected %0b got %0b", $time, e.limited, limited);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_ADDR_W-1:0]     cfg_addr;
  logic [FIELD_W-1:0]        cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [FIELD_W-1:0] in_lateral_error;
  logic signed [FIELD_W-1:0] in_heading_error;
  logic signed [FIELD_W-1:0] in_path_curvature;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [FIELD_W-1:0] out_steer_angle;
  logic [QW-1:0]             out_drive_level;
  logic                      out_steer_limited;

  steer_cmd_ledger ledger;
  bit              in_burst;
  bit              out_burst;

  lane_steering_controller_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_lateral_error  (in_lateral_error),
    .in_heading_error  (in_heading_error),
    .in_path_curvature (in_path_curvature),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_steer_angle   (out_steer_angle),
    .out_drive_level   (out_drive_level),
    .out_steer_limited (out_steer_limited)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    ledger            = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_addr          = REG_PROP_GAIN;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_lateral_error  = '0;
    in_heading_error  = '0;
    in_path_curvature = '0;
    out_stall         = 1'b0;
    in_burst          = 1'b0;
    out_burst         = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_cmd(out_steer_angle, out_drive_level, out_steer_limited);
  end

  // Receiver: random stall before each word, with stall-free stretches
  initial begin
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 16);
      for (int k = 0; k < gap; k++) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_sample(logic [FIELD_W-1:0] lat, logic [FIELD_W-1:0] head,
                             logic [FIELD_W-1:0] curv);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    for (int k = 0; k < gap; k++) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid          = 1'b1;
    in_lateral_error  = lat;
    in_heading_error  = head;
    in_path_curvature = curv;
    do @(posedge clk); while (in_stall);
    ledger.note_sample(lat, head, curv);
  endtask

  // Hold the sender until every outstanding command has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.cmd_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(lsc_reg_t r, logic [FIELD_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = r;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    ledger.set_reg(r, v);
  endtask

  function automatic logic [FIELD_W-1:0] pick_field();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = FIELD_W'($urandom);
      2: v = FIELD_W'($urandom_range(0, 4095));
      3: v = FIELD_W'($urandom_range(0, 300));
      default: begin
        case ($urandom_range(0, 6))
          0: v = '0;
          1: v = 16'h7FFF;
          2: v = 16'h8000;
          3: v = 16'd205;
          4: v = 16'd204;
          5: v = 16'd2131;
          default: v = 16'd1;
        endcase
      end
    endcase
    // mirror about zero half the time
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic apply_setting(int ph);
    logic [FIELD_W-1:0] pg, hg, wb, lim, st, sf;
    pg  = FIELD_W'($urandom);
    hg  = FIELD_W'($urandom_range(0, 8191));
    wb  = FIELD_W'($urandom);
    lim = FIELD_W'($urandom_range(0, 32767));
    st  = FIELD_W'($urandom);
    sf  = FIELD_W'($urandom_range(1, 65535));
    case (ph)
      0: begin
        pg = CFG_RST.prop_gain; hg = CFG_RST.heading_gain; wb = CFG_RST.wheel_base;
        lim = FIELD_W'(CFG_RST.steer_limit); st = CFG_RST.speed_target;
        sf = CFG_RST.speed_full;
      end
      1: begin
        pg = 16'hFFFF; hg = 16'hFFFF; wb = 16'hFFFF;
        lim = 16'h7FFF; st = 16'hFFFF; sf = 16'hFFFF;
      end
      2: begin
        pg = '0; hg = '0; wb = '0; lim = '0; st = '0; sf = 16'd1;
      end
      3: begin
        st = 16'hFFFF; sf = 16'd1; lim = FIELD_W'($urandom_range(0, 4095));
      end
      4: begin
        // divider by zero reports full level
        sf = '0; pg = FIELD_W'($urandom_range(0, 8191));
      end
      5: begin
        pg = FIELD_W'($urandom_range(0, 2048)); hg = FIELD_W'($urandom_range(0, 2048));
        st = FIELD_W'($urandom_range(0, 20000)); sf = FIELD_W'($urandom_range(1, 20000));
      end
      default: ;
    endcase
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_HEADING_GAIN, hg);
    write_reg(REG_WHEEL_BASE, wb);
    write_reg(REG_STEER_LIMIT, lim);
    write_reg(REG_SPEED_TARGET, st);
    write_reg(REG_SPEED_FULL, sf);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed words at the reset setting
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h0000);
    send_sample(16'h8000, 16'h7FFF, 16'h0000);
    send_sample(16'd2130, 16'h0000, 16'h0000);
    send_sample(16'd2131, 16'h0000, 16'h0000);
    send_sample(-16'd2130, 16'h0000, 16'h0000);
    send_sample(-16'd2131, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'd204);
    send_sample(16'h0000, 16'h0000, 16'd205);
    send_sample(16'h0000, 16'h0000, -16'd204);
    send_sample(16'h0000, 16'h0000, -16'd205);
    send_sample(16'h0000, 16'h0000, 16'd1000);
    send_sample(16'h0000, 16'h0000, -16'd1000);
    send_sample(16'h0000, 16'h0000, 16'd1);
    send_sample(16'h0000, 16'h0000, -16'd1);
    send_sample(16'h0000, 16'd100, 16'h0000);
    send_sample(16'h0000, -16'd100, 16'h0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(ph);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 3 && n == PER_PHASE / 2) drain();
        send_sample(pick_field(), pick_field(), pick_field());
      end
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (ledger.errors == 0 && ledger.cmd_due.size() == 0)
      $display("lane_steering_controller_core: match");
    else
      $display("lane_steering_controller_core: mismatch");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("lane_steering_controller_core: mismatch");
    $finish;
  end

endmodule

/* lane_steering_controller_core.f */
rtl/lsc_pkg.sv
rtl/lsc_front.sv
rtl/lsc_cell.sv
rtl/lsc_back.sv
rtl/lane_steering_controller_core.sv
tb/sv/lane_steering_controller_core_tb.sv
